### hdl/mmc_pkg.sv
// Shared types and constants of the minimum Mahalanobis distance classifier.
package mmc_pkg;

    localparam int DIST_W = 48;
    localparam int CODE_W = 8;

    localparam logic [1:0] OP_CODE   = 2'd0;
    localparam logic [1:0] OP_MEAN   = 2'd1;
    localparam logic [1:0] OP_COV    = 2'd2;
    localparam logic [1:0] OP_SAMPLE = 2'd3;

    localparam logic [1:0] REG_BANDS   = 2'd0;
    localparam logic [1:0] REG_CLASSES = 2'd1;
    localparam logic [1:0] REG_THR_EN  = 2'd2;
    localparam logic [1:0] REG_THR     = 2'd3;

    typedef enum logic [2:0] {
        K_CODE,
        K_MEAN,
        K_COV,
        K_SAMPLE,
        K_RUN
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  slot;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic [15:0] sample;
    } t_cmd;

endpackage

### hdl/min_mahalanobis_classifier_core.sv
// Top level of the minimum Mahalanobis distance classifier: register port and engine.
//
// Table writes (class code, mean, inverse covariance) and band samples enter as
// stream transfers and pass an input stage and a two-entry command queue. The
// sample of the last band in use starts a classification, carried out by the
// single shared multiply-accumulate pipeline that walks one matrix entry per
// cycle; the result then waits in an output register while further transfers
// are queued.
module min_mahalanobis_classifier_core #(
    parameter int MAX_BANDS   = 8,
    parameter int MAX_CLASSES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // slot, row, col, table_value, sample
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // class_code, min_distance
    output logic [0:0]  m_axis_tuser,   // found
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import mmc_pkg::*;

    localparam int NBW = $clog2(MAX_BANDS + 1);
    localparam int CW  = $clog2(MAX_CLASSES + 1);

    logic [3:0]        r_bands;
    logic [4:0]        r_classes;
    logic              r_thr_en;
    logic [DIST_W-1:0] r_thr;
    logic [NBW-1:0]    nb;
    logic [CW-1:0]     nc;
    logic              wr;

    logic  f_valid, f_ready, q_valid, q_ready;
    t_cmd  f_cmd, q_cmd;
    logic [CODE_W-1:0] code;
    logic [DIST_W-1:0] min_dist;
    logic              found;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bands   <= 4'd1;
            r_classes <= '0;
            r_thr_en  <= 1'b0;
            r_thr     <= '0;
        end else if (wr) begin
            case (paddr[4:3])
                REG_BANDS:   r_bands   <= pwdata[3:0];
                REG_CLASSES: r_classes <= pwdata[4:0];
                REG_THR_EN:  r_thr_en  <= pwdata[0];
                REG_THR:     r_thr     <= pwdata[DIST_W-1:0];
                default:     r_thr_en  <= r_thr_en;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_BANDS:   prdata = 64'(r_bands);
            REG_CLASSES: prdata = 64'(r_classes);
            REG_THR_EN:  prdata = 64'(r_thr_en);
            REG_THR:     prdata = 64'(r_thr);
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        if (r_bands == 4'd0) begin
            nb = NBW'(1);
        end else if (32'(r_bands) > MAX_BANDS) begin
            nb = NBW'(MAX_BANDS);
        end else begin
            nb = NBW'(r_bands);
        end
        if (32'(r_classes) > MAX_CLASSES) begin
            nc = CW'(MAX_CLASSES);
        end else begin
            nc = CW'(r_classes);
        end
    end

    mmc_front #(
        .MAX_BANDS   (MAX_BANDS),
        .MAX_CLASSES (MAX_CLASSES),
        .NBW         (NBW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_operation   (s_axis_tuser),
        .i_slot        (s_axis_tdata[3:0]),
        .i_row         (s_axis_tdata[6:4]),
        .i_col         (s_axis_tdata[9:7]),
        .i_table_value (s_axis_tdata[41:10]),
        .i_sample      (s_axis_tdata[57:42]),
        .i_nb          (nb),
        .o_cmd_valid   (f_valid),
        .o_cmd         (f_cmd),
        .i_cmd_ready   (f_ready)
    );

    mmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    mmc_back #(
        .MAX_BANDS   (MAX_BANDS),
        .MAX_CLASSES (MAX_CLASSES),
        .NBW         (NBW),
        .CW          (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .i_nb        (nb),
        .i_nc        (nc),
        .i_thr_en    (r_thr_en),
        .i_thr       (r_thr),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_code      (code),
        .o_found     (found),
        .o_dist      (min_dist)
    );

    assign m_axis_tdata = {min_dist, code};
    assign m_axis_tuser = found;

endmodule

### hdl/mmc_front.sv
// Input stage: accept stream transfers, classify them and drop out-of-range writes.
module mmc_front #(
    parameter int MAX_BANDS   = 8,
    parameter int MAX_CLASSES = 16,
    parameter int NBW         = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_operation,
    input  logic [3:0]     i_slot,
    input  logic [2:0]     i_row,
    input  logic [2:0]     i_col,
    input  logic [31:0]    i_table_value,
    input  logic [15:0]    i_sample,
    input  logic [NBW-1:0] i_nb,
    output logic           o_cmd_valid,
    output mmc_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_ready
);
    import mmc_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    logic  keep;
    t_kind kind;
    logic  slot_ok, row_ok, col_ok, last_band;

    assign slot_ok   = 32'(i_slot) < MAX_CLASSES;
    assign row_ok    = 32'(i_row) < MAX_BANDS;
    assign col_ok    = 32'(i_col) < MAX_BANDS;
    assign last_band = 32'(i_row) == (32'(i_nb) - 32'd1);

    always_comb begin
        keep = 1'b0;
        kind = K_CODE;
        case (i_operation)
            OP_CODE: begin
                kind = K_CODE;
                keep = slot_ok;
            end
            OP_MEAN: begin
                kind = K_MEAN;
                keep = slot_ok && row_ok;
            end
            OP_COV: begin
                kind = K_COV;
                keep = slot_ok && row_ok && col_ok;
            end
            OP_SAMPLE: begin
                kind = last_band ? K_RUN : K_SAMPLE;
                keep = row_ok;
            end
            default: begin
                kind = K_CODE;
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= keep;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd.kind   <= kind;
            r_cmd.slot   <= i_slot;
            r_cmd.row    <= i_row;
            r_cmd.col    <= i_col;
            r_cmd.value  <= i_table_value;
            r_cmd.sample <= i_sample;
        end
    end

endmodule

### hdl/mmc_queue.sv
// Two-entry command queue between the input stage and the compute engine.
module mmc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mmc_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output mmc_pkg::t_cmd o_cmd
);
    import mmc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

### hdl/mmc_back.sv
// Compute engine: class tables, band samples and the per-class quadratic form.
module mmc_back #(
    parameter int MAX_BANDS   = 8,
    parameter int MAX_CLASSES = 16,
    parameter int NBW         = 4,
    parameter int CW          = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  mmc_pkg::t_cmd             i_cmd,
    output logic                      o_cmd_ready,
    input  logic [NBW-1:0]            i_nb,
    input  logic [CW-1:0]             i_nc,
    input  logic                      i_thr_en,
    input  logic [mmc_pkg::DIST_W-1:0] i_thr,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [mmc_pkg::CODE_W-1:0] o_code,
    output logic                      o_found,
    output logic [mmc_pkg::DIST_W-1:0] o_dist
);
    import mmc_pkg::*;

    localparam int BW     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int SW     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int MDEPTH = MAX_CLASSES * MAX_BANDS;
    localparam int CDEPTH = MDEPTH * MAX_BANDS;
    localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DPH,
        S_DWAIT,
        S_QPH,
        S_QDRAIN,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state;
    logic [BW-1:0] r_k, r_i, r_j, r_kd;
    logic [SW-1:0] r_slot;
    logic          r_vd;
    logic [3:0]    r_v;
    logic          r_found;
    logic [DIST_W-1:0] r_best;
    logic [CODE_W-1:0] r_code;
    logic          r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic          r_out_found;
    logic [DIST_W-1:0] r_out_dist;

    logic [15:0]        r_smp_mem  [MAX_BANDS];
    logic [23:0]        r_mean_mem [MDEPTH];
    logic [31:0]        r_cov_mem  [CDEPTH];
    logic [CODE_W-1:0]  r_code_mem [MAX_CLASSES];
    logic signed [25:0] r_dmem     [MAX_BANDS];

    logic [15:0]        r_smp_rd;
    logic [23:0]        r_mean_rd;
    logic [CODE_W-1:0]  r_code_rd;
    logic signed [25:0] r_di, r_dj;
    logic signed [31:0] r_m1, r_m2;
    logic signed [51:0] r_p;
    logic signed [57:0] r_plo;
    logic signed [58:0] r_phi;
    logic signed [83:0] r_full;
    logic signed [65:0] r_acc;

    logic exec, we_smp;
    logic last_k, last_q, last_s;
    logic signed [25:0] d_val;
    logic [MAW-1:0] mean_waddr, mean_raddr;
    logic [CAW-1:0] cov_waddr, cov_raddr;
    logic [DIST_W-1:0] dist_c;
    logic qualify;

    assign exec        = (r_state == S_IDLE) && i_cmd_valid;
    assign o_cmd_ready = r_state == S_IDLE;
    assign we_smp      = exec && (i_cmd.kind == K_SAMPLE || i_cmd.kind == K_RUN);

    assign last_k = 32'(r_k) == (32'(i_nb) - 32'd1);
    assign last_q = (32'(r_i) == (32'(i_nb) - 32'd1)) && (32'(r_j) == (32'(i_nb) - 32'd1));
    assign last_s = 32'(r_slot) == (32'(i_nc) - 32'd1);

    assign mean_waddr = MAW'(32'(i_cmd.slot) * MAX_BANDS + 32'(i_cmd.row));
    assign cov_waddr  = CAW'((32'(i_cmd.slot) * MAX_BANDS + 32'(i_cmd.row)) * MAX_BANDS
                             + 32'(i_cmd.col));
    assign mean_raddr = MAW'(32'(r_slot) * MAX_BANDS + 32'(r_k));
    assign cov_raddr  = CAW'((32'(r_slot) * MAX_BANDS + 32'(r_i)) * MAX_BANDS + 32'(r_j));

    assign d_val = $signed({2'b00, r_smp_rd, 8'h00}) - $signed({2'b00, r_mean_rd});

    always_comb begin
        if (r_acc[65]) begin
            dist_c = '0;
        end else if (|r_acc[64:DIST_W]) begin
            dist_c = '1;
        end else begin
            dist_c = r_acc[DIST_W-1:0];
        end
    end

    assign qualify = !i_thr_en || (dist_c < i_thr);

    always_ff @(posedge i_clk) begin
        if (we_smp) begin
            r_smp_mem[BW'(i_cmd.row)] <= i_cmd.sample;
        end
        r_smp_rd <= r_smp_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (exec && i_cmd.kind == K_MEAN) begin
            r_mean_mem[mean_waddr] <= i_cmd.value[23:0];
        end
        r_mean_rd <= r_mean_mem[mean_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (exec && i_cmd.kind == K_COV) begin
            r_cov_mem[cov_waddr] <= i_cmd.value;
        end
        r_m1 <= $signed(r_cov_mem[cov_raddr]);
    end

    always_ff @(posedge i_clk) begin
        if (exec && i_cmd.kind == K_CODE) begin
            r_code_mem[SW'(i_cmd.slot)] <= i_cmd.value[CODE_W-1:0];
        end
        r_code_rd <= r_code_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (r_vd) begin
            r_dmem[r_kd] <= d_val;
        end
        r_di <= r_dmem[r_i];
        r_dj <= r_dmem[r_j];
    end

    always_ff @(posedge i_clk) begin
        r_kd   <= r_k;
        r_p    <= r_di * r_dj;
        r_m2   <= r_m1;
        r_plo  <= $signed({1'b0, r_p[24:0]}) * r_m2;
        r_phi  <= $signed(r_p[51:25]) * r_m2;
        r_full <= (84'(r_phi) <<< 25) + 84'(r_plo);
        if (r_state == S_DWAIT) begin
            r_acc <= '0;
        end else if (r_v[3]) begin
            r_acc <= r_acc + 66'($signed(r_full[83:24]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_slot      <= '0;
            r_vd        <= 1'b0;
            r_v         <= '0;
            r_found     <= 1'b0;
            r_best      <= '0;
            r_code      <= '0;
            r_out_valid <= 1'b0;
            r_out_code  <= '0;
            r_out_found <= 1'b0;
            r_out_dist  <= '0;
        end else begin
            r_vd <= r_state == S_DPH;
            r_v  <= {r_v[2:0], r_state == S_QPH};
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (exec && i_cmd.kind == K_RUN) begin
                        r_slot  <= '0;
                        r_k     <= '0;
                        r_found <= 1'b0;
                        r_best  <= '0;
                        r_code  <= '0;
                        r_state <= (i_nc == '0) ? S_DONE : S_DPH;
                    end
                end
                S_DPH: begin
                    if (last_k) begin
                        r_state <= S_DWAIT;
                    end else begin
                        r_k <= r_k + BW'(1);
                    end
                end
                S_DWAIT: begin
                    r_i     <= '0;
                    r_j     <= '0;
                    r_state <= S_QPH;
                end
                S_QPH: begin
                    if (last_q) begin
                        r_state <= S_QDRAIN;
                    end else if (32'(r_j) == (32'(i_nb) - 32'd1)) begin
                        r_j <= '0;
                        r_i <= r_i + BW'(1);
                    end else begin
                        r_j <= r_j + BW'(1);
                    end
                end
                S_QDRAIN: begin
                    if (r_v == '0) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (qualify && (!r_found || dist_c < r_best)) begin
                        r_found <= 1'b1;
                        r_best  <= dist_c;
                        r_code  <= r_code_rd;
                    end
                    if (last_s) begin
                        r_state <= S_DONE;
                    end else begin
                        r_slot  <= r_slot + SW'(1);
                        r_k     <= '0;
                        r_state <= S_DPH;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_code  <= r_code;
                        r_out_found <= r_found;
                        r_out_dist  <= r_best;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_code  = r_out_code;
    assign o_found = r_out_found;
    assign o_dist  = r_out_dist;

endmodule

### dv/tb_min_mahalanobis_classifier_core.sv
// Testbench of the minimum Mahalanobis distance classifier core with its scoreboard.
module tb_min_mahalanobis_classifier_core;
    import mmc_pkg::*;

    typedef struct {
        logic [7:0]  code;
        logic        found;
        logic [47:0] min_dist;
    } t_verdict;

    class class_scoreboard;
        logic [15:0] band_smp[8];
        logic [23:0] means[16][8];
        logic [31:0] inv_cov[16][8][8];
        logic [7:0]  codes[16];
        logic [3:0]  bands_reg;
        logic [4:0]  classes_reg;
        logic        thr_en;
        logic [47:0] thr_sq;
        t_verdict    verdicts[$];
        int          errors;
        int          n_results;
        int          n_found;

        function new();
            bands_reg = 4'd1;
            classes_reg = 5'd0;
            thr_en = 1'b0;
            thr_sq = '0;
            errors = 0;
            n_results = 0;
            n_found = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                REG_BANDS:   bands_reg = value[3:0];
                REG_CLASSES: classes_reg = value[4:0];
                REG_THR_EN:  thr_en = value[0];
                REG_THR:     thr_sq = value[47:0];
                default: ;
            endcase
        endfunction

        function logic [47:0] distance(int s, int nb);
            logic signed [95:0] acc;
            logic signed [95:0] d[8];
            logic signed [95:0] c;
            acc = '0;
            for (int i = 0; i < nb; i++) begin
                d[i] = 96'(band_smp[i]) * 256 - 96'(means[s][i]);
            end
            for (int i = 0; i < nb; i++) begin
                for (int j = 0; j < nb; j++) begin
                    c = 96'(signed'(inv_cov[s][i][j]));
                    acc = acc + ((d[i] * d[j] * c) >>> 24);
                end
            end
            if (acc < 0) return '0;
            if (acc > 96'sd281474976710655) return '1;
            return acc[47:0];
        endfunction

        function void note_input(logic [1:0] op, logic [3:0] slot, logic [2:0] row,
                                 logic [2:0] col, logic [31:0] val, logic [15:0] smp);
            int nb;
            int nc;
            logic [47:0] cand;
            t_verdict v;
            case (op)
                OP_CODE: codes[slot] = val[7:0];
                OP_MEAN: means[slot][row] = val[23:0];
                OP_COV:  inv_cov[slot][row][col] = val;
                default: begin
                    band_smp[row] = smp;
                    nb = (bands_reg == 0) ? 1 : (bands_reg > 8) ? 8 : int'(bands_reg);
                    if (row == nb - 1) begin
                        nc = (classes_reg > 16) ? 16 : int'(classes_reg);
                        v = '{code: 8'd0, found: 1'b0, min_dist: 48'd0};
                        for (int s = 0; s < nc; s++) begin
                            cand = distance(s, nb);
                            if (!(thr_en && !(cand < thr_sq)) &&
                                (!v.found || cand < v.min_dist))
                                v = '{code: codes[s], found: 1'b1, min_dist: cand};
                        end
                        verdicts.push_back(v);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [7:0] code, logic found, logic [47:0] min_dist);
            t_verdict v;
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result code=%0d found=%0d dist=%0d",
                         $time, code, found, min_dist);
                errors++;
                return;
            end
            v = verdicts.pop_front();
            n_results++;
            if (found) n_found++;
            if (code !== v.code) begin
                $display("%0t: class_code expected %0d actual %0d", $time, v.code, code);
                errors++;
            end
            if (found !== v.found) begin
                $display("%0t: found expected %0d actual %0d", $time, v.found, found);
                errors++;
            end
            if (min_dist !== v.min_dist) begin
                $display("%0t: min_distance expected %0d actual %0d", $time, v.min_dist,
                         min_dist);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    class_scoreboard sb = new();
    int snd_idle = 27;
    int rcv_idle = 74;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int n_items = 0;
    bit code_w[16];
    bit mean_w[16][8];
    bit cov_w[16][8][8];
    bit smp_w[8];

    min_mahalanobis_classifier_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #300_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: check each transfer, stall at random or for a long hold-off.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[55:8]);
            if (hold_req) begin
                hold_left = 3000;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    task automatic send(logic [1:0] op, logic [3:0] slot, logic [2:0] row, logic [2:0] col,
                        logic [31:0] val, logic [15:0] smp);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {6'd0, smp, val, col, row, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, slot, row, col, val, smp);
        n_items++;
        case (op)
            OP_CODE: code_w[slot] = 1'b1;
            OP_MEAN: mean_w[slot][row] = 1'b1;
            OP_COV:  cov_w[slot][row][col] = 1'b1;
            default: smp_w[row] = 1'b1;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.verdicts.size() != 0) @(posedge i_clk);
        repeat (1400) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 3;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    function automatic logic [31:0] pick_cov();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_mean();
        return $urandom_range(1) ? $urandom
                                 : {8'($urandom_range(255)), 8'h00, 16'($urandom)};
    endfunction

    task automatic fill_tables(int nb, int nc);
        for (int s = 0; s < nc; s++) begin
            if (!code_w[s]) send(OP_CODE, 4'(s), 3'd0, 3'd0, $urandom, 16'd0);
            for (int r = 0; r < nb; r++) begin
                if (!mean_w[s][r]) send(OP_MEAN, 4'(s), 3'(r), 3'd0, pick_mean(), 16'd0);
                for (int c = 0; c < nb; c++)
                    if (!cov_w[s][r][c]) send(OP_COV, 4'(s), 3'(r), 3'(c), pick_cov(), 16'd0);
            end
        end
    endtask

    task automatic random_items(int nb, int count);
        int last;
        int pick;
        logic [2:0] row;
        bit ready;
        last = n_items + count;
        while (n_items < last) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                for (int b = 0; b < nb; b++) send(OP_SAMPLE, 4'($urandom), 3'(b),
                                                  3'($urandom), $urandom, pick_sample());
            end else if (pick < 90) begin
                case ($urandom_range(2))
                    0: send(OP_CODE, 4'($urandom), 3'($urandom), 3'($urandom), $urandom,
                            16'($urandom));
                    1: send(OP_MEAN, 4'($urandom), 3'($urandom), 3'($urandom), pick_mean(),
                            16'($urandom));
                    default: send(OP_COV, 4'($urandom), 3'($urandom), 3'($urandom),
                                  pick_cov(), 16'($urandom));
                endcase
            end else begin
                row = 3'($urandom_range(7));
                ready = 1'b1;
                for (int b = 0; b < nb - 1; b++) ready &= smp_w[b];
                if (row == nb - 1 && !ready) row = 3'd0;
                send(OP_SAMPLE, 4'($urandom), row, 3'($urandom), $urandom, pick_sample());
            end
        end
    endtask

    task automatic run_phase(logic [3:0] bands, logic [4:0] classes, logic en,
                             logic [47:0] thr, int count);
        int nb;
        int nc;
        nb = (bands == 0) ? 1 : (bands > 8) ? 8 : int'(bands);
        nc = (classes > 16) ? 16 : int'(classes);
        drain();
        apb_write(REG_BANDS, 64'(bands) | ({$urandom, $urandom} & ~64'hF));
        apb_write(REG_CLASSES, 64'(classes));
        apb_write(REG_THR_EN, 64'(en));
        apb_write(REG_THR, 64'(thr) | 64'hFFFF_0000_0000_0000);
        fill_tables(nb, nc);
        random_items(nb, count);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_write(REG_BANDS, 64'd0);
        apb_write(REG_CLASSES, 64'd2);
        send(OP_CODE, 4'd0, 3'd0, 3'd0, 32'h0000_0000, 16'd0);
        send(OP_CODE, 4'd1, 3'd0, 3'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send(OP_MEAN, 4'd0, 3'd0, 3'd0, 32'h0000_0000, 16'd0);
        send(OP_MEAN, 4'd1, 3'd0, 3'd0, 32'h80FF_FFFF, 16'd0);
        send(OP_COV, 4'd0, 3'd0, 3'd0, 32'h7FFF_FFFF, 16'd0);
        send(OP_COV, 4'd1, 3'd0, 3'd0, 32'h8000_0000, 16'd0);
        send(OP_SAMPLE, 4'hF, 3'd0, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        send(OP_SAMPLE, 4'd0, 3'd0, 3'd0, 32'd0, 16'h0000);
        send(OP_COV, 4'd1, 3'd0, 3'd0, 32'h0100_0000, 16'd0);
        send(OP_SAMPLE, 4'd0, 3'd0, 3'd0, 32'd0, 16'd12345);
        send(OP_SAMPLE, 4'd0, 3'd0, 3'd0, 32'd0, 16'd65280);
        drain();
        apb_write(REG_THR_EN, 64'd1);
        send(OP_SAMPLE, 4'd0, 3'd0, 3'd0, 32'd0, 16'd1);
        drain();
        apb_write(REG_THR, 64'hFFFF_FFFF_FFFF);
        send(OP_SAMPLE, 4'd0, 3'd0, 3'd0, 32'd0, 16'd40000);
        send(OP_SAMPLE, 4'd0, 3'd0, 3'd0, 32'd0, 16'h0000);

        run_phase(4'd2, 5'd4, 1'b1, 48'($urandom_range(1 << 30)) << 14, 150);
        snd_idle = 74;
        rcv_idle = 27;
        run_phase(4'd3, 5'd3, 1'b1, 48'hFFFF_FFFF_FFFF, 150);
        run_phase(4'd15, 5'd2, 1'b0, 48'd0, 40);
        snd_idle = 0;
        rcv_idle = 0;
        run_phase(4'd1, 5'd0, 1'b1, 48'd0, 60);
        drain();
        hold_req = 1'b1;
        run_phase(4'd4, 5'd31, 1'b1, 48'($urandom) << 12, 170);
        run_phase(4'd8, 5'd5, 1'b0, 48'd0, 60);

        drain();
        $display("Covered %0d transfers in and %0d results (%0d with a class found)",
                 n_items, sb.n_results, sb.n_found);
        $display("Settings ranged over 1..8 bands, 0..16 slots, threshold on and off");
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
